### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define NNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that requires a consequence in the next cycle.
`define NNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// Types and constants shared by the nearest-neighbor tour unit.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int MAX_CITIES_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int IN_W       = 16;
  localparam int CITY_W     = 6;
  localparam int NUM_W      = 7;
  localparam int START_W    = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [NUM_W-1:0] NUM_RESET = 7'd64;

  // Register selects, taken from the word address bit.
  localparam logic REG_NUM_CITIES = 1'b0;
  localparam logic REG_START_CITY = 1'b1;

  typedef struct packed {
    logic [IN_W-1:0] city_x;
    logic [IN_W-1:0] city_y;
  } nnt_in_t;

  typedef struct packed {
    logic [CITY_W-1:0] tour_city;
    logic              tour_end;
  } nnt_out_t;

  // Tag that travels with each candidate through the distance pipeline.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [CITY_W-1:0] idx;
  } nnt_tag_t;

endpackage

### design/nnt_dist_unit.sv
// ----------------------------------------------------------------------------
// nnt_dist_unit
// Three-stage squared distance pipeline: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
module nnt_dist_unit #(
  parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nnt_pkg::nnt_tag_t       tag_in,
  input  logic [COORD_BITS-1:0]   cand_x,
  input  logic [COORD_BITS-1:0]   cand_y,
  input  logic [COORD_BITS-1:0]   cur_x,
  input  logic [COORD_BITS-1:0]   cur_y,
  output nnt_pkg::nnt_tag_t       tag_out,
  output logic [2*COORD_BITS:0]   dist_out,
  output logic [COORD_BITS-1:0]   cx_out,
  output logic [COORD_BITS-1:0]   cy_out
);

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 1;

  nnt_pkg::nnt_tag_t     s1_tag_r, s2_tag_r, s3_tag_r;
  logic [COORD_BITS-1:0] s1_dx_r, s1_dy_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r, s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  logic [SQ_W-1:0]       s2_dx2_r, s2_dy2_r;
  logic [DIST_W-1:0]     s3_d_r;
  logic [COORD_BITS-1:0] dx, dy;

  assign dx = (cand_x > cur_x) ? (cand_x - cur_x) : (cur_x - cand_x);
  assign dy = (cand_y > cur_y) ? (cand_y - cur_y) : (cur_y - cand_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r  <= dx;
    s1_dy_r  <= dy;
    s1_x_r   <= cand_x;
    s1_y_r   <= cand_y;
    s2_dx2_r <= SQ_W'(s1_dx_r) * SQ_W'(s1_dx_r);
    s2_dy2_r <= SQ_W'(s1_dy_r) * SQ_W'(s1_dy_r);
    s2_x_r   <= s1_x_r;
    s2_y_r   <= s1_y_r;
    s3_d_r   <= DIST_W'(s2_dx2_r) + DIST_W'(s2_dy2_r);
    s3_x_r   <= s2_x_r;
    s3_y_r   <= s2_y_r;
  end

  assign tag_out  = s3_tag_r;
  assign dist_out = s3_d_r;
  assign cx_out   = s3_x_r;
  assign cy_out   = s3_y_r;

endmodule

### design/nearest_neighbour_tour_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_unit
// Loads city coordinates and emits a greedy nearest-neighbor tour over them.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Transfer when
// input     start, busy, in_data                    start high while busy low
// result    out_valid, out_data                     out_valid high, one cycle
// config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite high
//           prdata, pready
//
// Loading takes one cycle per city; busy stays low while cities are loaded.
// After the last city of a run, the tour starts. For N cities, each tour step
// reads all N coordinates from the single read port of the coordinate memory,
// one per cycle, and the next step starts once the last candidate has passed
// the read register, the three-stage distance unit and the compare.
// Reset is synchronous and clears the control state; the coordinate memory
// needs no clearing. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_unit #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nnt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [nnt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [nnt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  // City input.
  input  logic                               start,
  output logic                               busy,
  input  nnt_pkg::nnt_in_t                   in_data,
  // Tour output.
  output logic                               out_valid,
  output nnt_pkg::nnt_out_t                  out_data
);

  localparam int IDX_W  = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int MEM_W  = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam logic [nnt_pkg::IN_W-1:0] IN_MASK = (COORD_BITS >= nnt_pkg::IN_W) ?
      {nnt_pkg::IN_W{1'b1}} : nnt_pkg::IN_W'((32'd1 << COORD_BITS) - 32'd1);
  localparam logic [nnt_pkg::NUM_W-1:0] MAX_NUM = nnt_pkg::NUM_W'(MAX_CITIES);
  localparam logic [nnt_pkg::NUM_W-1:0] MIN_NUM = nnt_pkg::NUM_W'(2);

  typedef enum logic [2:0] {S_LOAD, S_FETCH, S_SEED, S_SCAN, S_WAIT} state_t;

  // --------------------------------------------------------------------------
  // Configuration registers. Registers are decoded by the word address bit,
  // so the byte offset bits are ignored.
  // --------------------------------------------------------------------------
  logic [nnt_pkg::NUM_W-1:0]   num_cities_r;
  logic [nnt_pkg::START_W-1:0] start_city_r;
  logic                        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cities_r <= nnt_pkg::NUM_RESET;
      start_city_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        nnt_pkg::REG_NUM_CITIES: num_cities_r <= pwdata[nnt_pkg::NUM_W-1:0];
        nnt_pkg::REG_START_CITY: start_city_r <= pwdata[nnt_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      nnt_pkg::REG_NUM_CITIES: prdata = nnt_pkg::CFG_DATA_W'(num_cities_r);
      nnt_pkg::REG_START_CITY: prdata = nnt_pkg::CFG_DATA_W'(start_city_r);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Effective city count and first city. A count below two acts as two and a
  // count beyond the memory depth acts as the depth; a start city outside the
  // count falls back to city zero.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] start_sel;

  always_comb begin
    if (num_cities_r < MIN_NUM) begin
      n_eff = CNT_W'(2);
    end else if (num_cities_r > MAX_NUM) begin
      n_eff = CNT_W'(MAX_CITIES);
    end else begin
      n_eff = CNT_W'(num_cities_r);
    end
  end

  assign start_sel = (8'(start_city_r) < 8'(n_eff)) ? IDX_W'(start_city_r) : '0;

  // --------------------------------------------------------------------------
  // Registers of the control path.
  // --------------------------------------------------------------------------
  state_t                state_r;
  logic [CNT_W-1:0]      lc_r;        // cities loaded in this run
  logic [CNT_W-1:0]      n_r;         // city count latched for the tour
  logic [IDX_W-1:0]      first_r;
  logic [CNT_W-1:0]      pos_r;       // results emitted so far in this tour
  logic [IDX_W-1:0]      scan_idx_r;
  logic [MAX_CITIES-1:0] visited_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [DIST_W-1:0]     best_d_r;
  logic [COORD_BITS-1:0] best_x_r, best_y_r;
  logic                  found_r;
  nnt_pkg::nnt_tag_t     tag0_r;
  logic                  out_valid_r;
  nnt_pkg::nnt_out_t     out_data_r;

  logic                  in_acc;
  logic [CNT_W-1:0]      lc_inc;
  logic                  tour_go;
  logic                  scan_last;
  nnt_pkg::nnt_tag_t     scan_tag;

  assign busy    = (state_r != S_LOAD);
  assign in_acc  = start & ~busy;
  assign lc_inc  = lc_r + 1'b1;
  assign tour_go = in_acc && (lc_inc >= n_eff);

  // The tag of the candidate read in this scan cycle.
  assign scan_last = (CNT_W'(scan_idx_r) == n_r - 1'b1);
  assign scan_tag  = '{valid: 1'b1, last: scan_last, idx: nnt_pkg::CITY_W'(scan_idx_r)};

  // --------------------------------------------------------------------------
  // Coordinate memory: x in the low half of a word, y in the high half. It is
  // written while loading and read once per cycle during the tour, so a write
  // and a read never meet in the same cycle.
  // --------------------------------------------------------------------------
  logic [MEM_W-1:0]      coord_mem [MAX_CITIES];
  logic [MEM_W-1:0]      rd_data_r;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [COORD_BITS-1:0] x_m, y_m;

  assign x_m     = COORD_BITS'(in_data.city_x & IN_MASK);
  assign y_m     = COORD_BITS'(in_data.city_y & IN_MASK);
  assign rd_en   = (state_r == S_FETCH) || (state_r == S_SCAN);
  assign rd_addr = (state_r == S_FETCH) ? first_r : scan_idx_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      coord_mem[lc_r[IDX_W-1:0]] <= {y_m, x_m};
    end
    if (rd_en) begin
      rd_data_r <= coord_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Distance pipeline. The tag registered with each read lines up with the
  // memory output in the following cycle.
  // --------------------------------------------------------------------------
  nnt_pkg::nnt_tag_t     t3_tag;
  logic [DIST_W-1:0]     t3_d;
  logic [COORD_BITS-1:0] t3_x, t3_y;

  nnt_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (tag0_r),
    .cand_x   (rd_data_r[COORD_BITS-1:0]),
    .cand_y   (rd_data_r[MEM_W-1:COORD_BITS]),
    .cur_x    (cur_x_r),
    .cur_y    (cur_y_r),
    .tag_out  (t3_tag),
    .dist_out (t3_d),
    .cx_out   (t3_x),
    .cy_out   (t3_y)
  );

  // --------------------------------------------------------------------------
  // Compare. Visited cities are skipped; a strictly smaller distance replaces
  // the best so far, so ties keep the lowest index seen first.
  // --------------------------------------------------------------------------
  logic                  take;
  logic [IDX_W-1:0]      sel_idx;
  logic [COORD_BITS-1:0] sel_x, sel_y;
  logic                  last_pos;

  assign take     = t3_tag.valid && !visited_r[t3_tag.idx[IDX_W-1:0]] &&
                    (!found_r || (t3_d < best_d_r));
  assign sel_idx  = take ? t3_tag.idx[IDX_W-1:0] : best_idx_r;
  assign sel_x    = take ? t3_x : best_x_r;
  assign sel_y    = take ? t3_y : best_y_r;
  assign last_pos = (pos_r == n_r - 1'b1);

  // --------------------------------------------------------------------------
  // Sequencer. Loading stores one city per transfer. A tour fetches the first
  // city, then repeats a scan of all loaded cities for every further position
  // and commits the winner when the last candidate leaves the pipeline.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      lc_r        <= '0;
      n_r         <= '0;
      first_r     <= '0;
      pos_r       <= '0;
      scan_idx_r  <= '0;
      visited_r   <= '0;
      found_r     <= 1'b0;
      tag0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A result leaves with the first city and with every committed winner.
      out_valid_r <= (state_r == S_SEED) || (t3_tag.valid && t3_tag.last);
      tag0_r      <= (state_r == S_SCAN) ? scan_tag : '0;

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (tour_go) begin
              lc_r    <= '0;
              n_r     <= n_eff;
              first_r <= start_sel;
              state_r <= S_FETCH;
            end else begin
              lc_r <= lc_inc;
            end
          end
        end
        S_FETCH: begin
          visited_r <= '0;
          state_r   <= S_SEED;
        end
        S_SEED: begin
          cur_x_r             <= rd_data_r[COORD_BITS-1:0];
          cur_y_r             <= rd_data_r[MEM_W-1:COORD_BITS];
          visited_r[first_r]  <= 1'b1;
          out_data_r          <= '{tour_city: nnt_pkg::CITY_W'(first_r), tour_end: 1'b0};
          pos_r               <= CNT_W'(1);
          scan_idx_r          <= '0;
          found_r             <= 1'b0;
          state_r             <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_last) begin
            state_r <= S_WAIT;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        S_WAIT: ;
        default: state_r <= S_LOAD;
      endcase

      // Candidates arrive while the scan is still issuing reads, so the
      // compare runs in both scan states.
      if (t3_tag.valid) begin
        if (t3_tag.last) begin
          cur_x_r            <= sel_x;
          cur_y_r            <= sel_y;
          visited_r[sel_idx] <= 1'b1;
          out_data_r         <= '{tour_city: nnt_pkg::CITY_W'(sel_idx), tour_end: last_pos};
          found_r            <= 1'b0;
          scan_idx_r         <= '0;
          if (last_pos) begin
            state_r <= S_LOAD;
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= S_SCAN;
          end
        end else if (take) begin
          best_idx_r <= sel_idx;
          best_d_r   <= t3_d;
          best_x_r   <= sel_x;
          best_y_r   <= sel_y;
          found_r    <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/nnt_checker.sv
// ----------------------------------------------------------------------------
// nnt_checker
// Port-level checks on the result strobe and the busy flag of the tour unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nnt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input nnt_pkg::nnt_out_t out_data
);

  // No result follows another at once; results of one tour are at least a full scan apart.
  `NNT_ASSERT_NEXT(a_no_adjacent_results, out_valid, !out_valid, "back-to-back results")

  // The transfer of a city is never followed at once by a result.
  `NNT_ASSERT_NEXT(a_no_result_after_load, start && !busy, !out_valid, "result right after load")

  // More results follow any result that is not the last of its tour.
  `NNT_ASSERT(a_busy_mid_tour, (out_valid && !out_data.tour_end) |-> busy, "idle mid-tour")

  // The final result comes with the unit ready for the next run.
  `NNT_ASSERT(a_idle_at_end, (out_valid && out_data.tour_end) |-> !busy, "busy after tour end")

  // The unit only leaves a tour by delivering its final result.
  `NNT_ASSERT(a_end_marks_idle, $fell(busy) |-> (out_valid && out_data.tour_end), "idle too early")

endmodule

bind nearest_neighbour_tour_unit nnt_checker u_nnt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
